FILE: design/slt_pkg.sv
// Shared types and constants for the sorted list table.
`timescale 1ns / 1ps

package slt_pkg;

   localparam int CAPACITY_DEFAULT    = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   typedef enum logic [2:0] {
      ACT_INSERT = 3'd0,
      ACT_SEARCH = 3'd1,
      ACT_REMOVE = 3'd2,
      ACT_COUNT  = 3'd3,
      ACT_DUMP   = 3'd4
   } slt_action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_BAD_POS   = 2'd3
   } slt_status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_ROTATE = 2'd3
   } slt_op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DUMP = 1'b1
   } slt_state_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
      logic [3:0]         position;
   } slt_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] entry_value;
      logic [3:0]         entry_position;
      logic [4:0]         entry_count;
      logic               last;
   } slt_rsp_type;

   // Handed from each cell to its right neighbor.
   typedef struct packed {
      logic below;    // occupied and smaller than the request value
      logic match;    // occupied and equal to the request value
   } slt_link_type;

   // Per-cell decode results gathered by the chain.
   typedef struct packed {
      logic ins_here;
      logic first_hit;
      logic picked;
   } slt_flags_type;

endpackage

FILE: design/sorted_list_table.sv
// Top level of the sorted list table: request decode, dump sequencer, result register.
`timescale 1ns / 1ps

// Channel  Direction  Ports                            Beat
// req      in         req_valid, req_stall, req_data   one action
// rsp      out        rsp_valid, rsp_stall, rsp_data   one result
//
// Insert, search, remove and count give one result beat each: every cell compares against
// the request value at once and the row shifts in the same edge that loads the result.
// A dump gives one beat per entry by rotating the row through cell 0 (an empty table gives
// one not-found beat); no request is taken until its last beat.
// A stalled result holds the result register and with it the request side.
// Reset empties the table; cell contents are not cleared.

module sorted_list_table #(
   parameter int CAPACITY    = slt_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = slt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  slt_pkg::slt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output slt_pkg::slt_rsp_type rsp_data
);

   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int IW  = $clog2(CAPACITY);
   localparam int PCW = (CW > 4) ? CW : 4;

   slt_pkg::slt_state_type state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          dump_idx_ff, dump_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   slt_pkg::slt_rsp_type   rsp_ff, rsp_in;

   slt_pkg::slt_op_type    op;
   logic                   load;
   logic                   out_free, take, full, pos_ok, dump_last;
   logic [VALUE_WIDTH-1:0] req_val;
   logic [IW-1:0]          ins_pos, hit_pos;
   logic                   hit;
   logic [VALUE_WIDTH-1:0] head_value, pick_value;

   assign req_val   = VALUE_WIDTH'(req_data.value);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != slt_pkg::ST_IDLE) || !out_free;
   assign take      = req_valid && !req_stall;
   assign full      = count_ff == CW'(CAPACITY);
   assign pos_ok    = PCW'(req_data.position) < PCW'(count_ff);
   assign dump_last = dump_idx_ff == count_ff - CW'(1);

   slt_chain #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_chain (
      .clock      (clock),
      .op         (op),
      .cmd_value  (req_val),
      .position   (CW'(req_data.position)),
      .count      (count_ff),
      .ins_pos    (ins_pos),
      .hit        (hit),
      .hit_pos    (hit_pos),
      .head_value (head_value),
      .pick_value (pick_value)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      dump_idx_in = dump_idx_ff;
      op          = slt_pkg::OP_HOLD;
      load        = 1'b0;
      rsp_in      = rsp_ff;
      case (state_ff)
         slt_pkg::ST_IDLE: begin
            if (take) begin
               case (req_data.action)
                  slt_pkg::ACT_INSERT: begin
                     load = 1'b1;
                     if (full) begin
                        rsp_in = '{slt_pkg::STAT_FULL, 32'($signed(req_val)), 4'd0,
                                   5'(count_ff), 1'b1};
                     end else begin
                        op       = slt_pkg::OP_INSERT;
                        count_in = count_ff + CW'(1);
                        rsp_in   = '{slt_pkg::STAT_OK, 32'($signed(req_val)), 4'(ins_pos),
                                     5'(count_ff + CW'(1)), 1'b1};
                     end
                  end
                  slt_pkg::ACT_SEARCH: begin
                     load = 1'b1;
                     if (hit) begin
                        rsp_in = '{slt_pkg::STAT_OK, 32'($signed(req_val)), 4'(hit_pos),
                                   5'(count_ff), 1'b1};
                     end else begin
                        rsp_in = '{slt_pkg::STAT_NOT_FOUND, 32'($signed(req_val)), 4'd0,
                                   5'(count_ff), 1'b1};
                     end
                  end
                  slt_pkg::ACT_REMOVE: begin
                     load = 1'b1;
                     if (pos_ok) begin
                        op       = slt_pkg::OP_REMOVE;
                        count_in = count_ff - CW'(1);
                        rsp_in   = '{slt_pkg::STAT_OK, 32'($signed(pick_value)),
                                     req_data.position, 5'(count_ff - CW'(1)), 1'b1};
                     end else begin
                        rsp_in = '{slt_pkg::STAT_BAD_POS, 32'sd0, req_data.position,
                                   5'(count_ff), 1'b1};
                     end
                  end
                  slt_pkg::ACT_COUNT: begin
                     load   = 1'b1;
                     rsp_in = '{slt_pkg::STAT_OK, 32'sd0, 4'd0, 5'(count_ff), 1'b1};
                  end
                  slt_pkg::ACT_DUMP: begin
                     load = 1'b1;
                     if (count_ff == '0) begin
                        rsp_in = '{slt_pkg::STAT_NOT_FOUND, 32'sd0, 4'd0, 5'd0, 1'b1};
                     end else begin
                        // emit the head now and rotate the next entry into cell 0
                        op     = slt_pkg::OP_ROTATE;
                        rsp_in = '{slt_pkg::STAT_OK, 32'($signed(head_value)), 4'd0,
                                   5'(count_ff), count_ff == CW'(1)};
                        if (count_ff != CW'(1)) begin
                           state_in    = slt_pkg::ST_DUMP;
                           dump_idx_in = CW'(1);
                        end
                     end
                  end
                  default: begin
                     load = 1'b0;
                  end
               endcase
            end
         end
         slt_pkg::ST_DUMP: begin
            if (out_free) begin
               op          = slt_pkg::OP_ROTATE;
               load        = 1'b1;
               rsp_in      = '{slt_pkg::STAT_OK, 32'($signed(head_value)),
                               4'(dump_idx_ff), 5'(count_ff), dump_last};
               dump_idx_in = dump_idx_ff + CW'(1);
               if (dump_last) begin
                  state_in = slt_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = slt_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slt_pkg::ST_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      take && (req_data.action == slt_pkg::ACT_INSERT) && !full
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the table by one");

   a_dump_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slt_pkg::ST_DUMP) |-> (dump_idx_ff != '0) && (dump_idx_ff < count_ff))
      else $error("dump index outside the occupied cells");

   a_more_beats: assert property (@(posedge clock) disable iff (reset)
      load && !rsp_in.last |-> (state_in == slt_pkg::ST_DUMP))
      else $error("non-final beat without a dump in progress");

endmodule

FILE: design/slt_cell.sv
// One storage cell of the sorted list chain.
`timescale 1ns / 1ps

module slt_cell #(
   parameter int CAPACITY    = slt_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = slt_pkg::VALUE_WIDTH_DEFAULT,
   parameter int INDEX       = 0
) (
   input  logic                              clock,
   input  slt_pkg::slt_op_type               op,
   input  logic [VALUE_WIDTH-1:0]            cmd_value,
   input  logic [$clog2(CAPACITY+1)-1:0]     position,
   input  logic [$clog2(CAPACITY+1)-1:0]     count,
   input  logic [VALUE_WIDTH-1:0]            left_value,
   input  logic [VALUE_WIDTH-1:0]            right_value,
   input  logic [VALUE_WIDTH-1:0]            head_value,
   input  slt_pkg::slt_link_type             link_prev,
   output slt_pkg::slt_link_type             link_next,
   output slt_pkg::slt_flags_type            flags,
   output logic [VALUE_WIDTH-1:0]            value
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   occupied, less, equal, tail;

   assign occupied = CW'(INDEX) < count;
   assign less     = $signed(value_ff) < $signed(cmd_value);
   assign equal    = value_ff == cmd_value;
   assign tail     = CW'(INDEX + 1) == count;

   assign link_next.below = occupied & less;
   assign link_next.match = occupied & equal;

   assign flags.ins_here  = link_prev.below & ~link_next.below;
   assign flags.first_hit = link_next.match & ~link_prev.match;
   assign flags.picked    = CW'(INDEX) == position;

   always_comb begin
      value_in = value_ff;
      case (op)
         slt_pkg::OP_INSERT: begin
            // everything at or past the insert point moves one place right
            if (!link_prev.below) begin
               value_in = left_value;
            end else if (!link_next.below) begin
               value_in = cmd_value;
            end
         end
         slt_pkg::OP_REMOVE: begin
            if (CW'(INDEX) >= position) begin
               value_in = right_value;
            end
         end
         slt_pkg::OP_ROTATE: begin
            // the head wraps to the last occupied cell
            value_in = tail ? head_value : right_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: design/slt_chain.sv
// Row of cells with the position encoders and the removed-value select.
`timescale 1ns / 1ps

module slt_chain #(
   parameter int CAPACITY    = slt_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = slt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  slt_pkg::slt_op_type               op,
   input  logic [VALUE_WIDTH-1:0]            cmd_value,
   input  logic [$clog2(CAPACITY+1)-1:0]     position,
   input  logic [$clog2(CAPACITY+1)-1:0]     count,
   output logic [$clog2(CAPACITY)-1:0]       ins_pos,
   output logic                              hit,
   output logic [$clog2(CAPACITY)-1:0]       hit_pos,
   output logic [VALUE_WIDTH-1:0]            head_value,
   output logic [VALUE_WIDTH-1:0]            pick_value
);

   localparam int IW = $clog2(CAPACITY);

   logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
   slt_pkg::slt_link_type  cell_link  [CAPACITY];
   slt_pkg::slt_flags_type cell_flags [CAPACITY];

   slt_pkg::slt_link_type  head_link;

   assign head_link.below = 1'b1;
   assign head_link.match = 1'b0;
   assign head_value      = cell_value[0];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      slt_cell #(
         .CAPACITY    (CAPACITY),
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (g)
      ) u_cell (
         .clock       (clock),
         .op          (op),
         .cmd_value   (cmd_value),
         .position    (position),
         .count       (count),
         .left_value  ((g == 0) ? '0 : cell_value[(g == 0) ? 0 : g - 1]),
         .right_value ((g == CAPACITY - 1) ? '0 : cell_value[(g == CAPACITY - 1) ? g : g + 1]),
         .head_value  (cell_value[0]),
         .link_prev   ((g == 0) ? head_link : cell_link[(g == 0) ? 0 : g - 1]),
         .link_next   (cell_link[g]),
         .flags       (cell_flags[g]),
         .value       (cell_value[g])
      );
   end

   // flags are one-hot at most, so OR-ing the indexes encodes them
   always_comb begin
      ins_pos    = '0;
      hit        = 1'b0;
      hit_pos    = '0;
      pick_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_flags[i].ins_here) begin
            ins_pos = ins_pos | IW'(i);
         end
         if (cell_flags[i].first_hit) begin
            hit     = 1'b1;
            hit_pos = hit_pos | IW'(i);
         end
         if (cell_flags[i].picked) begin
            pick_value = pick_value | cell_value[i];
         end
      end
   end

endmodule

FILE: tb/sorted_list_table_tb.sv
// Self-checking testbench for the sorted list table: directed table, then shaped random traffic.
`timescale 1ns / 1ps

module sorted_list_table_tb;
   import slt_pkg::*;

   localparam int CAP            = 16;
   localparam int RANDOM_ITEMS   = 380;
   localparam int CALM_ITEMS     = 60;
   localparam int HOLD_AFTER     = 150;
   localparam int HOLD_CYCLES    = 40;
   localparam int DRAIN_CYCLES   = 24;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // Action codes the block does not decode.
   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BOTH} mix_type;

   typedef struct {
      logic [2:0]         action;
      logic signed [31:0] value;
      logic [3:0]         position;
      int                 rep;
      bit                 typed;
      slt_rsp_type        want;
   } plan_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   slt_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   slt_rsp_type rsp_data;

   // Side information travelling with the beat on offer.
   bit          row_typed  = 1'b0;
   slt_rsp_type row_expect = '0;
   bit          calm       = 1'b0;

   logic signed [31:0] shadow_vals [CAP];
   int                 shadow_fill = 0;
   slt_rsp_type        step_results [$];
   slt_rsp_type        owed_results [$];
   slt_rsp_type        want_rsp;

   int n_taken = 0, n_checked = 0, n_bad = 0, n_dumps = 0, n_refused = 0;
   int quiet_cycles = 0;
   bit took, gave;

   sorted_list_table uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   function automatic slt_rsp_type make_rsp(slt_status_type st, logic signed [31:0] v,
                                            int pos, int cnt, bit fin);
      slt_rsp_type r;
      r.status         = st;
      r.entry_value    = v;
      r.entry_position = 4'(pos);
      r.entry_count    = 5'(cnt);
      r.last           = fin;
      return r;
   endfunction

   function automatic plan_row_type make_row(logic [2:0] act, logic signed [31:0] v,
                                             logic [3:0] pos, int rep, bit typed,
                                             slt_rsp_type want);
      plan_row_type row;
      row.action   = act;
      row.value    = v;
      row.position = pos;
      row.rep      = rep;
      row.typed    = typed;
      row.want     = want;
      return row;
   endfunction

   // Apply one request to the shadow list and leave its results in step_results.
   task automatic run_list_action(input slt_req_type rq);
      int                 slot, k;
      logic signed [31:0] v;
      logic signed [31:0] moved;
      v = rq.value;
      slot = 0;
      step_results.delete();
      case (rq.action)
         ACT_INSERT: begin
            if (shadow_fill >= CAP) begin
               step_results.push_back(make_rsp(STAT_FULL, v, 0, shadow_fill, 1'b1));
               n_refused++;
            end else begin
               while (slot < shadow_fill && shadow_vals[slot] < v) slot++;
               for (k = shadow_fill; k > slot; k--) shadow_vals[k] = shadow_vals[k - 1];
               shadow_vals[slot] = v;
               shadow_fill++;
               step_results.push_back(make_rsp(STAT_OK, v, slot, shadow_fill, 1'b1));
            end
         end
         ACT_SEARCH: begin
            while (slot < shadow_fill && shadow_vals[slot] != v) slot++;
            if (slot < shadow_fill)
               step_results.push_back(make_rsp(STAT_OK, v, slot, shadow_fill, 1'b1));
            else
               step_results.push_back(make_rsp(STAT_NOT_FOUND, v, 0, shadow_fill, 1'b1));
         end
         ACT_REMOVE: begin
            slot = int'(rq.position);
            if (slot >= shadow_fill) begin
               step_results.push_back(make_rsp(STAT_BAD_POS, 0, slot, shadow_fill, 1'b1));
            end else begin
               moved = shadow_vals[slot];
               for (k = slot; k + 1 < shadow_fill; k++) shadow_vals[k] = shadow_vals[k + 1];
               shadow_fill--;
               step_results.push_back(make_rsp(STAT_OK, moved, slot, shadow_fill, 1'b1));
            end
         end
         ACT_COUNT: step_results.push_back(make_rsp(STAT_OK, 0, 0, shadow_fill, 1'b1));
         ACT_DUMP: begin
            n_dumps++;
            if (shadow_fill == 0)
               step_results.push_back(make_rsp(STAT_NOT_FOUND, 0, 0, 0, 1'b1));
            else
               for (k = 0; k < shadow_fill; k++)
                  step_results.push_back(make_rsp(STAT_OK, shadow_vals[k], k, shadow_fill,
                                                  k == shadow_fill - 1));
         end
         default: ;
      endcase
   endtask

   // Offer one beat and hold it until taken.
   task automatic offer(input slt_req_type item, input bit typed, input slt_rsp_type want);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_data   <= item;
      row_typed  <= typed;
      row_expect <= want;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         took = req_valid && !req_stall;
         gave = rsp_valid && !rsp_stall;
         if (took) begin
            run_list_action(req_data);
            if (row_typed) owed_results.push_back(row_expect);
            else foreach (step_results[k]) owed_results.push_back(step_results[k]);
            n_taken++;
         end
         if (gave) begin
            if (owed_results.size() == 0) begin
               n_bad++;
               if (n_bad <= REPORT_LIMIT)
                  $display("unexpected result: st=%0d val=%0d pos=%0d cnt=%0d last=%0d",
                           rsp_data.status, rsp_data.entry_value, rsp_data.entry_position,
                           rsp_data.entry_count, rsp_data.last);
            end else begin
               want_rsp = owed_results.pop_front();
               n_checked++;
               if (rsp_data.status !== want_rsp.status
                   || rsp_data.entry_value !== want_rsp.entry_value
                   || rsp_data.entry_position !== want_rsp.entry_position
                   || rsp_data.entry_count !== want_rsp.entry_count
                   || rsp_data.last !== want_rsp.last) begin
                  n_bad++;
                  if (n_bad <= REPORT_LIMIT)
                     $display("mismatch: want st=%0d val=%0d pos=%0d cnt=%0d last=%0d, %s",
                              want_rsp.status, want_rsp.entry_value, want_rsp.entry_position,
                              want_rsp.entry_count, want_rsp.last,
                              $sformatf("got st=%0d val=%0d pos=%0d cnt=%0d last=%0d",
                                        rsp_data.status, rsp_data.entry_value,
                                        rsp_data.entry_position, rsp_data.entry_count,
                                        rsp_data.last));
               end
            end
         end
         quiet_cycles = (took || gave) ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results owed",
                     quiet_cycles, owed_results.size());
            $display("sorted_list_table_tb: errors");
            $finish;
         end
      end
   end

   // Receiver: short random stalls, one long hold-off, none near the end.
   initial begin
      int stall_left;
      bit held_off;
      stall_left = 0;
      held_off   = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!held_off && n_taken >= HOLD_AFTER) begin
            held_off   = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      plan_row_type       plan [$];
      slt_req_type        rq;
      logic signed [31:0] recent [16];
      int                 recent_at, gen_fill, n_rand, seg, pick, ins_cut, rem_cut, r;
      mix_type            mix;
      bit                 idle_on;

      foreach (recent[k]) recent[k] = '0;
      recent_at = 0;
      gen_fill  = 0;
      n_rand    = 0;
      seg       = 0;
      idle_on   = 1'b1;
      mix       = MIX_BOTH;

      plan.push_back(make_row(ACT_COUNT,  0, 0, 1, 1, make_rsp(STAT_OK, 0, 0, 0, 1)));
      plan.push_back(make_row(ACT_DUMP,   0, 0, 1, 1, make_rsp(STAT_NOT_FOUND, 0, 0, 0, 1)));
      plan.push_back(make_row(ACT_SEARCH, 5, 0, 1, 1, make_rsp(STAT_NOT_FOUND, 5, 0, 0, 1)));
      plan.push_back(make_row(ACT_REMOVE, 0, 15, 1, 1, make_rsp(STAT_BAD_POS, 0, 15, 0, 1)));
      plan.push_back(make_row(ACT_INSERT, VAL_MAX, 0, 1, 1,
                              make_rsp(STAT_OK, VAL_MAX, 0, 1, 1)));
      plan.push_back(make_row(ACT_INSERT, VAL_MIN, 0, 1, 1,
                              make_rsp(STAT_OK, VAL_MIN, 0, 2, 1)));
      plan.push_back(make_row(ACT_SEARCH, VAL_MAX, 0, 1, 0, '0));
      plan.push_back(make_row(ACT_SPARE_LO, -1, 15, 1, 0, '0));
      plan.push_back(make_row(ACT_SPARE_HI, VAL_MIN, 0, 1, 0, '0));
      // Fill to capacity with repeating small values so duplicates pile up.
      plan.push_back(make_row(ACT_INSERT, -1, 0, 14, 0, '0));
      plan.push_back(make_row(ACT_INSERT, 99, 0, 1, 1, make_rsp(STAT_FULL, 99, 0, 16, 1)));
      plan.push_back(make_row(ACT_SEARCH, 1, 0, 1, 0, '0));
      plan.push_back(make_row(ACT_DUMP,   0, 0, 1, 0, '0));
      plan.push_back(make_row(ACT_REMOVE, 0, 15, 1, 0, '0));
      plan.push_back(make_row(ACT_REMOVE, 0, 15, 1, 1, make_rsp(STAT_BAD_POS, 0, 15, 15, 1)));
      plan.push_back(make_row(ACT_REMOVE, 0, 0, 1, 0, '0));
      plan.push_back(make_row(ACT_COUNT,  0, 0, 1, 0, '0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         for (r = 0; r < plan[i].rep; r++) begin
            rq.action   = plan[i].action;
            rq.value    = plan[i].value + (r % 4);
            rq.position = plan[i].position;
            offer(rq, plan[i].typed, plan[i].want);
            if ($urandom_range(0, 4) == 0) pause($urandom_range(1, 3));
         end
      end
      gen_fill = 14;

      while (n_rand < RANDOM_ITEMS) begin
         if (seg == 0) begin
            mix     = mix_type'($urandom_range(0, 2));
            idle_on = $urandom_range(0, 3) != 0;
            seg     = 24;
         end
         seg--;
         pick = $urandom_range(0, 9);
         if (pick < 6)       rq.value = $signed($urandom_range(0, 16)) - 8;
         else if (pick < 8)  rq.value = recent[$urandom_range(0, 15)];
         else if (pick < 9)  rq.value = $urandom;
         else begin
            case ($urandom_range(0, 3))
               0:       rq.value = VAL_MAX;
               1:       rq.value = VAL_MIN;
               2:       rq.value = -1;
               default: rq.value = 0;
            endcase
         end
         rq.position = 4'($urandom_range(0, 15));

         ins_cut = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 15 : 35;
         rem_cut = ins_cut + ((mix == MIX_FILL) ? 10 : (mix == MIX_DRAIN) ? 45 : 20);
         pick = $urandom_range(0, 99);
         if (pick >= 96) begin
            rq.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
         end else if (pick < ins_cut) begin
            rq.action = ACT_INSERT;
            recent[recent_at] = rq.value;
            recent_at = (recent_at + 1) % 16;
            if (gen_fill < CAP) gen_fill++;
         end else if (pick < rem_cut) begin
            rq.action = ACT_REMOVE;
            if (gen_fill > 0 && $urandom_range(0, 4) != 0)
               rq.position = 4'($urandom_range(0, gen_fill - 1));
            if (rq.position < gen_fill) gen_fill--;
         end else if (pick < 80) begin
            rq.action = ACT_SEARCH;
            if ($urandom_range(0, 1) == 0) rq.value = recent[$urandom_range(0, 15)];
         end else if (pick < 86) begin
            rq.action = ACT_COUNT;
         end else begin
            rq.action = ACT_DUMP;
         end

         if (rq.action <= ACT_DUMP) n_rand++;
         if (n_rand >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         offer(rq, 1'b0, '0);
         if (idle_on && !calm && $urandom_range(0, 4) == 0) pause($urandom_range(1, 3));
      end
      pause(1);

      wait (owed_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (owed_results.size() != 0) begin
         $display("%0d results never arrived", owed_results.size());
         n_bad += owed_results.size();
      end

      $display("covered %0d requests and %0d checked results, %0d failures",
               n_taken, n_checked, n_bad);
      $display("covered %0d dumps and %0d inserts refused on a full table",
               n_dumps, n_refused);
      if (n_bad == 0)
         $display("sorted_list_table_tb: clean");
      else
         $display("sorted_list_table_tb: errors");
      $finish;
   end

endmodule

FILE: sim.f
design/slt_pkg.sv
design/slt_cell.sv
design/slt_chain.sv
design/sorted_list_table.sv
tb/sorted_list_table_tb.sv
